/* hw/rtl/lhp_pkg.sv */
// Shared types and constants for the latency histogram percentile unit.
`default_nettype none

package lhp_pkg;

   localparam int LAT_W       = 32;
   localparam int OUT_W       = 10;

   // floor(x / 1000) = floor((x >> 3) * RECIP_M >> RECIP_SHIFT) for 32-bit x
   localparam int PRE_SHIFT   = 3;
   localparam int N_W         = LAT_W - PRE_SHIFT;
   localparam int M_W         = 30;
   localparam int PROD_W      = N_W + M_W;
   localparam int RECIP_SHIFT = 36;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;
   localparam logic [M_W-1:0] RECIP_M = M_W'(549755814);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_RECORD   = 1'b0;
   localparam logic OP_SNAPSHOT = 1'b1;

   typedef struct packed {
      logic             op;
      logic [LAT_W-1:0] latency_ns;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] median_us;
      logic [OUT_W-1:0] p95_us;
      logic [OUT_W-1:0] p99_us;
      logic [OUT_W-1:0] max_us;
   } rsp_type;

   typedef struct packed {
      logic              clearing;
      logic [QCNT_W-1:0] q_count;
   } front_stat_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RECORD,
      BK_WALK,
      BK_DRAIN,
      BK_REPORT
   } back_state_type;

endpackage

`default_nettype wire

/* hw/rtl/latency_histogram_percentile_unit.sv */
// Top level of the latency histogram percentile unit.
`default_nettype none

// Command channel: a beat is taken on a rising edge with start high and busy
// low. op = record adds one sample to bucket min(latency_ns / 1000, last);
// op = snapshot returns the 50/95/99 percentile buckets and the highest
// nonempty bucket on rsp_data, marked by rsp_valid for exactly one cycle.
// Records give no result.
// A beat passes the registered divide-and-clamp front end, then waits in
// a four-entry queue. The engine runs one read-modify-write on the bucket RAM
// per record, in its idle and record states, and takes no new beat until the
// write is done; busy rises while the queue fills.
// A snapshot walks the RAM read port one bucket per cycle, then drains the
// compare pipeline before its result appears (an empty histogram skips the
// walk). Later beats queue up behind it.
// After reset the RAM is cleared one bucket per cycle, with busy held high.
// The receiver cannot stall the result channel.

module latency_histogram_percentile_unit
   import lhp_pkg::*;
#(
   parameter int NUM_BUCKETS = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(NUM_BUCKETS);

   front_stat_type    stat;
   logic              push;
   logic [IDX_W:0]    push_data;
   logic              pop;
   logic              q_valid;
   logic [IDX_W:0]    q_data;
   logic [QCNT_W-1:0] q_count;
   logic              clearing;

   assign stat.clearing = clearing;
   assign stat.q_count  = q_count;

   lhp_front #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .stat      (stat),
      .busy      (busy),
      .push      (push),
      .push_data (push_data)
   );

   lhp_queue #(
      .WIDTH (IDX_W + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_count   (q_count)
   );

   lhp_back #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* hw/rtl/lhp_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module lhp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/lhp_front.sv */
// Front end: accepts beats, divides latency by 1000 and clamps to a bucket.
`default_nettype none

module lhp_front
   import lhp_pkg::*;
#(
   parameter int NUM_BUCKETS = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire req_type                         req_data,
   input  wire front_stat_type                  stat,
   output logic                                 busy,
   output logic                                 push,
   output logic      [$clog2(NUM_BUCKETS):0]    push_data
);

   localparam int IDX_W = $clog2(NUM_BUCKETS);
   localparam logic [QUO_W-1:0] LAST_Q = QUO_W'(NUM_BUCKETS - 1);
   localparam logic [IDX_W-1:0] LAST_B = IDX_W'(NUM_BUCKETS - 1);

   logic              v1_ff, v1_in;
   logic              op1_ff;
   logic [N_W-1:0]    n1_ff;
   logic              v2_ff;
   logic              op2_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [QUO_W-1:0]  quo;
   logic [IDX_W-1:0]  bucket;
   logic [QCNT_W:0]   in_flight;

   assign in_flight = (QCNT_W+1)'(stat.q_count) + (QCNT_W+1)'(v1_ff) + (QCNT_W+1)'(v2_ff);
   assign busy      = stat.clearing || (in_flight >= (QCNT_W+1)'(QUEUE_DEPTH));
   assign v1_in     = start && !busy;
   assign prod_in   = n1_ff * RECIP_M;

   assign quo       = prod_ff[RECIP_SHIFT +: QUO_W];
   assign bucket    = (quo > LAST_Q) ? LAST_B : quo[IDX_W-1:0];
   assign push      = v2_ff;
   assign push_data = {op2_ff, bucket};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
      op1_ff  <= req_data.op;
      n1_ff   <= req_data.latency_ns[LAT_W-1:PRE_SHIFT];
      op2_ff  <= op1_ff;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/lhp_queue.sv */
// Short FIFO between the front end and the histogram engine.
`default_nettype none

module lhp_queue
   import lhp_pkg::*;
#(
   parameter int WIDTH = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [WIDTH-1:0]  push_data,
   input  wire logic              pop,
   output logic                   q_valid,
   output logic      [WIDTH-1:0]  q_data,
   output logic      [QCNT_W-1:0] q_count
);

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign q_data  = slot_ff[rd_ptr_ff];
   assign q_count = count_ff;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lhp_back.sv */
// Histogram engine: bucket update, clearing sweep and percentile walk.
`default_nettype none

module lhp_back
   import lhp_pkg::*;
#(
   parameter int NUM_BUCKETS = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_valid,
   input  wire logic [$clog2(NUM_BUCKETS):0] q_data,
   output logic                              q_pop,
   output logic                              clearing,
   output logic                              rsp_valid,
   output rsp_type                           rsp_data
);

   localparam int IDX_W = $clog2(NUM_BUCKETS);
   localparam int TOT_W = COUNT_WIDTH + IDX_W;
   localparam int SUM_W = TOT_W + 7;
   localparam int MUL_W = COUNT_WIDTH + 7;
   localparam logic [IDX_W-1:0]       LAST     = IDX_W'(NUM_BUCKETS - 1);
   localparam logic [COUNT_WIDTH-1:0] CNT_FULL = '1;
   localparam logic [SUM_W-1:0]       HUNDRED  = SUM_W'(100);

   back_state_type state_ff, state_in;

   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [IDX_W-1:0]       rec_ff, rec_in;
   logic [TOT_W-1:0]       total_ff, total_in;

   logic                   v1_ff, v2_ff, v3_ff, v1_in;
   logic [IDX_W-1:0]       idx1_ff, idx2_ff, idx3_ff;
   logic [MUL_W-1:0]       m_ff, m_in;
   logic                   nz_ff;
   logic [SUM_W-1:0]       s_ff, s_in;
   logic [SUM_W-1:0]       p_ff [3];
   logic [SUM_W-1:0]       p_in [3];
   logic [2:0]             found_ff, found_in;
   logic [IDX_W-1:0]       res_ff [3];
   logic [IDX_W-1:0]       res_in [3];
   logic [IDX_W-1:0]       maxb_ff, maxb_in;

   logic                   q_op;
   logic [IDX_W-1:0]       q_bucket;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [MUL_W-1:0]       rd_ext;
   logic [SUM_W-1:0]       tot_ext;
   logic                   at_last;
   logic                   start_walk;

   assign q_op     = q_data[IDX_W];
   assign q_bucket = q_data[IDX_W-1:0];
   assign at_last  = (addr_ff == LAST);
   assign rd_ext   = MUL_W'(rd_data);
   assign tot_ext  = SUM_W'(total_ff);

   lhp_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_BUCKETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (at_last) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (q_valid) begin
               if (q_op == OP_RECORD) state_in = BK_RECORD;
               else if (total_ff == '0) state_in = BK_REPORT;
               else state_in = BK_WALK;
            end
         end
         BK_RECORD: state_in = BK_IDLE;
         BK_WALK: begin
            if (at_last) state_in = BK_DRAIN;
         end
         BK_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) state_in = BK_REPORT;
         end
         BK_REPORT: state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      clearing  = 1'b0;
      rsp_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = rec_ff;
      wr_data   = COUNT_WIDTH'(rd_data + 1'b1);
      rd_addr   = q_bucket;
      case (state_ff)
         BK_CLEAR: begin
            clearing = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = addr_ff;
            wr_data  = '0;
         end
         BK_IDLE:   q_pop = q_valid;
         BK_RECORD: wr_en = (rd_data != CNT_FULL);
         BK_WALK:   rd_addr = addr_ff;
         BK_DRAIN:  ;
         BK_REPORT: rsp_valid = 1'b1;
         default:   ;
      endcase
   end

   assign start_walk = (state_ff == BK_IDLE) && q_valid && (q_op == OP_SNAPSHOT);

   // datapath
   always_comb begin
      addr_in  = addr_ff;
      rec_in   = rec_ff;
      total_in = total_ff;
      s_in     = s_ff;
      p_in     = p_ff;
      found_in = found_ff;
      res_in   = res_ff;
      maxb_in  = maxb_ff;
      v1_in    = (state_ff == BK_WALK);
      m_in     = (rd_ext << 6) + (rd_ext << 5) + (rd_ext << 2);

      if ((state_ff == BK_CLEAR) || (state_ff == BK_WALK)) begin
         addr_in = at_last ? '0 : IDX_W'(addr_ff + 1'b1);
      end
      if ((state_ff == BK_IDLE) && q_valid) begin
         rec_in = q_bucket;
      end
      if ((state_ff == BK_RECORD) && (rd_data != CNT_FULL)) begin
         total_in = TOT_W'(total_ff + 1'b1);
      end

      if (start_walk) begin
         // compare 100*(cum+1) > total*pct, i.e. cum >= floor(total*pct/100)
         s_in     = HUNDRED;
         p_in[0]  = (tot_ext << 5) + (tot_ext << 4) + (tot_ext << 1);
         p_in[1]  = (tot_ext << 6) + (tot_ext << 5) - tot_ext;
         p_in[2]  = (tot_ext << 6) + (tot_ext << 5) + (tot_ext << 1) + tot_ext;
         found_in = '0;
         maxb_in  = '0;
         for (int k = 0; k < 3; k++) begin
            res_in[k] = (total_ff == '0) ? '0 : LAST;
         end
      end else begin
         if (v2_ff) begin
            s_in = s_ff + SUM_W'(m_ff);
            if (nz_ff) maxb_in = idx2_ff;
         end
         if (v3_ff) begin
            for (int k = 0; k < 3; k++) begin
               if (!found_ff[k] && (s_ff > p_ff[k])) begin
                  found_in[k] = 1'b1;
                  res_in[k]   = idx3_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         addr_ff  <= '0;
         total_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         total_ff <= total_in;
         v1_ff    <= v1_in;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
      end
      rec_ff   <= rec_in;
      idx1_ff  <= addr_ff;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      m_ff     <= m_in;
      nz_ff    <= (rd_data != '0);
      s_ff     <= s_in;
      p_ff     <= p_in;
      found_ff <= found_in;
      res_ff   <= res_in;
      maxb_ff  <= maxb_in;
   end

   assign rsp_data.median_us = OUT_W'(res_ff[0]);
   assign rsp_data.p95_us    = OUT_W'(res_ff[1]);
   assign rsp_data.p99_us    = OUT_W'(res_ff[2]);
   assign rsp_data.max_us    = OUT_W'(maxb_ff);

endmodule

`default_nettype wire
